### rtl/core/ultrasonic_range_window_stats_core_defines.svh
// Assertion macros shared by the ranging core files.
`ifndef ULTRASONIC_RANGE_WINDOW_STATS_CORE_DEFINES_SVH
`define ULTRASONIC_RANGE_WINDOW_STATS_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define URWS_ASSERT_IMP(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("urws check failed");
`define URWS_ASSERT_NXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("urws check failed");
`else
`define URWS_ASSERT_IMP(lbl, ck, rs, a, c)
`define URWS_ASSERT_NXT(lbl, ck, rs, a, c)
`endif
`endif

### rtl/core/urws_pkg.sv
// Types and constants of the ultrasonic range window statistics core.
package urws_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;

  localparam int WIDTH_W = 16;
  localparam int TEMP_W  = 11;
  localparam int DIST_W  = 24;
  localparam int SPEED_W = 24;
  localparam int PROD_W  = WIDTH_W + SPEED_W - 1;
  localparam int SUM_W   = DIST_W + CNT_W;

  // divider: dividend holds width * speed (< 2^38) and the sample sum
  localparam int DIV_W       = 38;
  localparam int DVS_W       = 15;
  localparam int DIV_STEPS   = DIV_W / 2;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  // speed of sound in 0.1 mm/s units: 331.3 m/s + 0.606 m/s per degC
  localparam logic signed [SPEED_W-1:0] SPEED_BASE  = 24'sd3313000;
  localparam logic signed [SPEED_W-1:0] SPEED_SLOPE = 24'sd606;
  localparam logic [DVS_W-1:0]          RANGE_DIV   = 15'd20000;
  localparam logic [DIST_W-1:0]         DIST_MAX    = {DIST_W{1'b1}};

  localparam logic [CNT_W-1:0]          NUM_SAMPLES_RST = 7'd1;
  localparam logic signed [TEMP_W-1:0]  FALLBACK_RST    = 11'sd200;

  typedef enum logic {
    CFG_NUM_SAMPLES = 1'b0,
    CFG_FALLBACK    = 1'b1
  } cfg_idx_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SPEED = 8'b0000_0010,
    ST_MUL   = 8'b0000_0100,
    ST_DDIV  = 8'b0000_1000,
    ST_WRITE = 8'b0001_0000,
    ST_SCAN  = 8'b0010_0000,
    ST_ADIV  = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_resp_t;

endpackage

### rtl/core/urws_div.sv
// Radix-4 restoring divider, two quotient bits per cycle.
`include "ultrasonic_range_window_stats_core_defines.svh"
module urws_div (
  input  logic               clk,
  input  logic               rst,
  input  urws_pkg::div_req_t  req,
  output urws_pkg::div_resp_t resp
);
  import urws_pkg::*;

  logic [DIV_W-1:0]     quo;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [DVS_W:0]   r1, r2;
  logic [DVS_W-1:0] r1s, r2s;
  logic             ge1, ge2;

  always_comb begin
    r1  = {rem, quo[DIV_W-1]};
    ge1 = r1 >= {1'b0, dvs};
    r1s = ge1 ? DVS_W'(r1 - {1'b0, dvs}) : r1[DVS_W-1:0];
    r2  = {r1s, quo[DIV_W-2]};
    ge2 = r2 >= {1'b0, dvs};
    r2s = ge2 ? DVS_W'(r2 - {1'b0, dvs}) : r2[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-3:0], ge1, ge2};
      rem <= r2s;
    end
  end

  assign resp.busy = busy;
  assign resp.done = done;
  assign resp.quot = quo;

  `URWS_ASSERT_IMP(a_no_restart, clk, rst, req.start, !busy)
  `URWS_ASSERT_NXT(a_finish, clk, rst, busy && cnt == DIV_CNT_W'(1), done && !busy)
  `URWS_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)

endmodule

### rtl/core/ultrasonic_range_window_stats_core.sv
// Ultrasonic ranging core: distance from echo width, 64-entry ring, max and mean.
// Steps from input word to result word, n = entries in use:
//   speed, multiply, range divide, ring write, scan of n entries, mean divide, out;
//   no ended echo skips speed, multiply and divide, empty mean its divide.
// One word at a time: in_stall holds off the next word until the sequencer is idle again.
// Reset (rst, synchronous): valid bits, write index, distance clear; n = 1, fallback 200.
`include "ultrasonic_range_window_stats_core_defines.svh"
module ultrasonic_range_window_stats_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [urws_pkg::WIDTH_W-1:0]         echo_width_us,
  input  logic                                 echo_ended,
  input  logic                                 echo_started,
  input  logic signed [urws_pkg::TEMP_W-1:0]   temp_tenths,
  input  logic                                 temp_valid,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [urws_pkg::DIST_W-1:0]          last_dist_um,
  output logic [urws_pkg::DIST_W-1:0]          max_dist_um,
  output logic [urws_pkg::DIST_W-1:0]          avg_dist_um,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [urws_pkg::TEMP_W-1:0]          cfg_data
);
  import urws_pkg::*;

  // configuration
  logic [CNT_W-1:0]         num_samples;
  logic signed [TEMP_W-1:0] fallback_temp;
  logic [CNT_W-1:0]         n_use;

  // sequencer and working registers
  state_t                   state;
  logic [WIDTH_W-1:0]       width_r;
  logic                     ended_r;
  logic                     started_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic signed [SPEED_W-1:0] speed_r;
  logic [DIV_W-1:0]         prod;
  logic [DIST_W-1:0]        last_distance;
  logic [ADDR_W-1:0]        widx;
  logic                     div_go;

  // scan accumulators
  logic [CNT_W-1:0]         scan_cnt;
  logic                     rd_pend;
  logic [DIST_W-1:0]        mx;
  logic [SUM_W-1:0]         sum;
  logic [CNT_W-1:0]         k;
  logic                     zseen;
  logic [DIST_W-1:0]        avg;

  // sample ring: memory plus per-entry valid bits (cleared entry reads as zero)
  logic [DIST_W-1:0]        ring [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0]   vbits;
  logic [DIST_W-1:0]        rd_data;
  logic                     rd_vld;
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     wr_en;
  logic [DIST_W-1:0]        rd_val;

  // shared divider
  div_req_t                 div_req;
  div_resp_t                div_resp;

  logic                     in_acc;
  logic                     can_load;
  logic signed [SPEED_W-1:0] speed_next;
  logic [CNT_W:0]           widx_inc;

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign can_load  = !out_valid || !out_stall;

  always_comb begin
    if (num_samples == '0) begin
      n_use = CNT_W'(1);
    end else if (num_samples > CNT_W'(MAX_SAMPLES)) begin
      n_use = CNT_W'(MAX_SAMPLES);
    end else begin
      n_use = num_samples;
    end
  end

  // speed term stays positive for every 11-bit temperature
  assign speed_next = SPEED_BASE + SPEED_W'(SPEED_SLOPE * SPEED_W'(temp_r));
  assign widx_inc   = (CNT_W + 1)'(widx) + 1'b1;

  assign wr_en   = (state == ST_WRITE);
  assign rd_en   = (state == ST_SCAN) && (scan_cnt < n_use);
  assign rd_addr = scan_cnt[ADDR_W-1:0];
  assign rd_val  = rd_vld ? rd_data : '0;

  always_comb begin
    div_req.start = div_go;
    if (state == ST_ADIV) begin
      div_req.dividend = DIV_W'(sum);
      div_req.divisor  = DVS_W'(k);
    end else begin
      div_req.dividend = prod;
      div_req.divisor  = RANGE_DIV;
    end
  end

  urws_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples   <= NUM_SAMPLES_RST;
      fallback_temp <= FALLBACK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NUM_SAMPLES: num_samples   <= cfg_data[CNT_W-1:0];
        CFG_FALLBACK:    fallback_temp <= cfg_data;
        default: ;
      endcase
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[widx] <= last_distance;
    end
    if (rd_en) begin
      rd_data <= ring[rd_addr];
      rd_vld  <= vbits[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (wr_en) begin
      vbits[widx] <= 1'b1;
    end
  end

  // input word latch and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      width_r   <= echo_width_us;
      ended_r   <= echo_ended;
      started_r <= echo_started;
      temp_r    <= temp_valid ? temp_tenths : fallback_temp;
    end
    if (state == ST_SPEED) begin
      speed_r <= speed_next;
    end
    if (state == ST_MUL) begin
      prod <= DIV_W'(PROD_W'(width_r) * PROD_W'(speed_r[SPEED_W-2:0]));
    end
  end

  // divider start pulse: range divide after the multiply, mean divide after the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      div_go <= 1'b0;
    end else begin
      div_go <= ((state == ST_MUL) && (speed_r > 0))
             || ((state == ST_SCAN) && !rd_en && !rd_pend && (k != '0));
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      last_distance <= '0;
      widx          <= '0;
      rd_pend       <= 1'b0;
      scan_cnt      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (state == ST_FIN && can_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (echo_ended) begin
              state <= ST_SPEED;
            end else begin
              // started only: no answer; no edge: keep previous distance
              if (echo_started) begin
                last_distance <= '0;
              end
              state <= ST_WRITE;
            end
          end
        end
        ST_SPEED: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (speed_r <= 0) begin
            last_distance <= '0;
            state         <= ST_WRITE;
          end else begin
            state  <= ST_DDIV;
          end
        end
        ST_DDIV: begin
          if (div_resp.done) begin
            if (div_resp.quot > DIV_W'(DIST_MAX)) begin
              last_distance <= DIST_MAX;
            end else begin
              last_distance <= div_resp.quot[DIST_W-1:0];
            end
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          widx     <= (widx_inc >= (CNT_W + 1)'(n_use)) ? '0 : widx_inc[ADDR_W-1:0];
          scan_cnt <= '0;
          rd_pend  <= 1'b0;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          // one read issued per cycle, data processed in the next cycle
          if (rd_en) begin
            scan_cnt <= scan_cnt + 1'b1;
            rd_pend  <= 1'b1;
          end else begin
            rd_pend  <= 1'b0;
          end
          if (!rd_en && !rd_pend) begin
            state  <= ST_ADIV;
          end
        end
        ST_ADIV: begin
          if (k == '0 || div_resp.done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (can_load) begin
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // scan accumulators: max over entries in use, sum of leading nonzero run
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      mx    <= '0;
      sum   <= '0;
      k     <= '0;
      zseen <= 1'b0;
    end else if (state == ST_SCAN && rd_pend) begin
      if (rd_val > mx) begin
        mx <= rd_val;
      end
      if (!zseen) begin
        if (rd_val != '0) begin
          sum <= sum + SUM_W'(rd_val);
          k   <= k + 1'b1;
        end else begin
          zseen <= 1'b1;
        end
      end
    end
    if (state == ST_ADIV) begin
      avg <= (k == '0) ? '0 : div_resp.quot[DIST_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_FIN && can_load) begin
      last_dist_um <= last_distance;
      max_dist_um  <= mx;
      avg_dist_um  <= avg;
    end
  end

  `URWS_ASSERT_IMP(a_div_owner, clk, rst, div_resp.done, state == ST_DDIV || state == ST_ADIV)
  `URWS_ASSERT_NXT(a_accept_path, clk, rst, in_acc, state == ST_SPEED || state == ST_WRITE)
  `URWS_ASSERT_NXT(a_widx_wrap, clk, rst, state == ST_WRITE, (CNT_W'(widx) < n_use))
  `URWS_ASSERT_IMP(a_scan_bound, clk, rst, state == ST_SCAN, scan_cnt <= n_use)

endmodule
